### hdl/crcfr_pkg.sv
// Shared package for the CRC-checked frame receiver.
// Holds the sync and CRC constants, the queue sizing, the queued item type and the CRC byte step.
// No dependencies.
`default_nettype none

package crcfr_pkg;

    // Sync pair and CRC-16 polynomial (not reflected, zero initial value)
    localparam logic [7:0]  SYNC_FIRST      = 8'hFF;
    localparam logic [7:0]  SYNC_SECOND     = 8'h5A;
    localparam logic [15:0] CRC_POLY        = 16'h8005;
    localparam logic [15:0] CRC_INIT        = 16'h0000;

    // Frame length after reset, and the hard cap on the byte count
    localparam logic [7:0]  FRAME_LEN_RESET = 8'd86;
    localparam logic [7:0]  INDEX_LIMIT     = 8'd255;

    // Queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified frame byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] index;
        logic       last;
    } t_item;

    // CRC-16 update by one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/crc_checked_frame_receiver.sv
// Top level of the CRC-checked frame receiver: front classifier, queue, CRC back part.
// Also holds the frame length register.
// Depends on crcfr_pkg, crcfr_front, crcfr_queue, crcfr_back.
//
//  Channel   Dir  Handshake                     Payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata[7:0] rx_byte
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata[7:0] frame_byte, [15:8] byte_index,
//                                                  tlast frame_last, tuser crc_ok
//  cfg       in   i_cfg_valid/o_cfg_ready          data[7:0] frame_length
//
// One byte is taken every cycle while the queue is not full; a frame byte is written into a
// queue entry, then loaded into the output register once the output stage is free.
// The CRC step is one byte per cycle while items are popped into the output stage.
// Synchronous active-low reset; frame_length returns to 86 and the hunt restarts.
// A stalled output fills the two-entry queue before the input stalls; no clearing pass.
`default_nettype none

module crc_checked_frame_receiver (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] frame_byte, [15:8] byte_index
    output logic        o_m_axis_tlast,   // frame_last
    output logic        o_m_axis_tuser,   // crc_ok
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_data
);
    import crcfr_pkg::*;

    logic [7:0] r_frame_length;
    logic       q_push, q_full, q_pop, q_valid;
    t_item      front_item, queue_item;

    // Frame length register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= FRAME_LEN_RESET;
        end else if (i_cfg_valid) begin
            r_frame_length <= i_cfg_data;
        end
    end

    crcfr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .i_data         (i_s_axis_tdata),
        .o_ready        (o_s_axis_tready),
        .i_frame_length (r_frame_length),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_item         (front_item)
    );

    crcfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (queue_item)
    );

    crcfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (queue_item),
        .o_pop   (q_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast),
        .o_user  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

### hdl/crcfr_front.sv
// Front part: takes received bytes, hunts for the sync pair and numbers the frame bytes.
// Pushes each frame byte with its index and end-of-frame flag into the queue.
// Depends on crcfr_pkg.
`default_nettype none

module crcfr_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire  [7:0]          i_data,
    output logic                o_ready,
    input  wire  [7:0]          i_frame_length,
    input  wire                 i_full,
    output logic                o_push,
    output crcfr_pkg::t_item    o_item
);
    import crcfr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT_FF = 3'b001,
        PH_HUNT_5A = 3'b010,
        PH_COLLECT = 3'b100
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_count, n_count;
    logic [7:0] count_inc;
    logic       accept;

    assign o_ready   = !i_full;
    assign accept    = i_valid && !i_full;
    assign count_inc = r_count + 8'd1;

    // Sync hunt and byte numbering
    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        o_push       = 1'b0;
        o_item.data  = i_data;
        o_item.index = r_count;
        o_item.last  = 1'b0;
        if (accept) begin
            case (r_phase)
                PH_HUNT_FF: begin
                    if (i_data == SYNC_FIRST) begin
                        o_push       = 1'b1;
                        o_item.index = 8'd0;
                        n_count      = 8'd1;
                        n_phase      = PH_HUNT_5A;
                    end
                end
                PH_HUNT_5A: begin
                    if (i_data == SYNC_SECOND) begin
                        o_push       = 1'b1;
                        o_item.index = 8'd1;
                        n_count      = 8'd2;
                        n_phase      = PH_COLLECT;
                    end else begin
                        n_count = 8'd0;
                        n_phase = PH_HUNT_FF;
                    end
                end
                PH_COLLECT: begin
                    o_push = 1'b1;
                    // short lengths behave as three: count is at least three here
                    if (count_inc >= i_frame_length || count_inc == INDEX_LIMIT) begin
                        o_item.last = 1'b1;
                        n_count     = 8'd0;
                        n_phase     = PH_HUNT_FF;
                    end else begin
                        n_count = count_inc;
                    end
                end
                default: begin
                    n_count = 8'd0;
                    n_phase = PH_HUNT_FF;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT_FF;
            r_count <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // After the last byte of a frame the hunt restarts
    a_last_restarts_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.last) |=> (r_phase == PH_HUNT_FF && r_count == 8'd0))
        else $error("front: hunt not restarted after last byte");

    // While collecting, both sync bytes have been counted
    a_collect_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_COLLECT) |-> (r_count >= 8'd2))
        else $error("front: collecting with fewer than two bytes");

    // Nothing is pushed into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("front: push into full queue");

endmodule

`default_nettype wire

### hdl/crcfr_queue.sv
// Short queue between the front and back parts of the frame receiver.
// Register-based ring of QUEUE_DEPTH items with a fill count.
// Depends on crcfr_pkg.
`default_nettype none

module crcfr_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  crcfr_pkg::t_item    i_item,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output crcfr_pkg::t_item    o_item
);
    import crcfr_pkg::*;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Item storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue: fill count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue: pop from empty queue");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |-> !i_push)
        else $error("queue: push overflow");

endmodule

`default_nettype wire

### hdl/crcfr_back.sv
// Back part: runs the CRC-16 over frame bytes and drives the registered output stage.
// Flags a zero residue on the last byte of each frame.
// Depends on crcfr_pkg.
`default_nettype none

module crcfr_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  crcfr_pkg::t_item    i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [15:0]         o_data,
    output logic                o_last,
    output logic                o_user
);
    import crcfr_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] crc_in, crc_new;
    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic        r_out_last;
    logic        r_out_ok;

    // Take an item when the output stage is empty or being drained
    assign o_pop = i_valid && (!r_out_valid || i_ready);

    // A byte at index zero starts a fresh CRC
    assign crc_in  = (i_item.index == 8'd0) ? CRC_INIT : r_crc;
    assign crc_new = crc16_byte(crc_in, i_item.data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_crc       <= crc_new;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= {i_item.index, i_item.data};
            r_out_last <= i_item.last;
            r_out_ok   <= i_item.last && (crc_new == 16'h0000);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;
    assign o_user  = r_out_ok;

    a_ok_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_user) |-> o_last)
        else $error("back: crc_ok outside last byte");

    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> o_valid)
        else $error("back: popped item not presented");

    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_pop)
        else $error("back: item overwritten while stalled");

endmodule

`default_nettype wire

### sim/crcfr_checker.sv
// Checker for the CRC-checked frame receiver: watches the byte input, frame output and
// frame length channels, predicts every output item and compares it field by field.
// Depends on crcfr_pkg; also holds crcfr_tb_pkg with the CRC helper the stimulus shares.

`timescale 1ns / 1ps

package crcfr_tb_pkg;

    // CRC-16 step over one byte, fed one message bit at a time, MSB first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ crcfr_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

module crcfr_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [7:0]  i_s_tdata,     // [7:0] rx_byte
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [15:0] i_m_tdata,     // [7:0] frame_byte, [15:8] byte_index
    input  wire         i_m_tlast,     // frame_last
    input  wire         i_m_tuser,     // crc_ok
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire  [7:0]  i_cfg_data,    // frame_length
    output int          o_fail_count,
    output int          o_pending
);

    import crcfr_pkg::*;
    import crcfr_tb_pkg::*;

    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        IN_FRAME,
        PHASE_SPARE
    } t_rx_phase;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [7:0] byte_index;
        logic       frame_last;
        logic       crc_ok;
    } t_frame_item;

    // Predicted output items, oldest first
    t_frame_item frame_expect[$];

    // Shadow of the deframer state and the frame length register
    t_rx_phase   rx_phase;
    logic [7:0]  rx_count;
    logic [15:0] rx_crc;
    logic [7:0]  frame_len;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic restart_hunt();
        rx_phase = HUNT_FIRST;
        rx_count = '0;
        rx_crc   = CRC_INIT;
    endtask

    // Advance the shadow state by one received byte, queueing the item it produces
    task automatic predict_rx_byte(input logic [7:0] b);
        t_frame_item it;
        it = '{frame_byte: b, byte_index: 8'd0, frame_last: 1'b0, crc_ok: 1'b0};
        case (rx_phase)
            HUNT_FIRST: begin
                if (b == SYNC_FIRST) begin
                    rx_crc   = crc16_update(CRC_INIT, b);
                    rx_count = 8'd1;
                    rx_phase = HUNT_SECOND;
                    frame_expect.push_back(it);
                end else begin
                    restart_hunt();
                end
            end
            HUNT_SECOND: begin
                // anything but the second sync byte, a repeated 0xFF included, drops out
                if (b == SYNC_SECOND) begin
                    it.byte_index = 8'd1;
                    rx_crc        = crc16_update(rx_crc, b);
                    rx_count      = 8'd2;
                    rx_phase      = IN_FRAME;
                    frame_expect.push_back(it);
                end else begin
                    restart_hunt();
                end
            end
            IN_FRAME: begin
                it.byte_index = rx_count;
                rx_crc        = crc16_update(rx_crc, b);
                rx_count      = rx_count + 8'd1;
                // frame ends at the configured length, or at the index cap
                if (rx_count >= frame_len || rx_count >= INDEX_LIMIT) begin
                    it.frame_last = 1'b1;
                    it.crc_ok     = (rx_crc == 16'h0000);
                    restart_hunt();
                end
                frame_expect.push_back(it);
            end
            default: begin
                restart_hunt();
            end
        endcase
    endtask

    // Sample all three channels at the rising edge
    always @(posedge i_clk) begin
        t_frame_item want;
        if (!i_rst_n) begin
            frame_expect.delete();
            frame_len    = FRAME_LEN_RESET;
            o_fail_count = 0;
            restart_hunt();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                frame_len = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_rx_byte(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (frame_expect.size() == 0) begin
                    report_mismatch("unexpected output item, tdata", i_m_tdata, -1);
                end else begin
                    want = frame_expect.pop_front();
                    if (i_m_tdata[7:0] != want.frame_byte) begin
                        report_mismatch("frame_byte", i_m_tdata[7:0], want.frame_byte);
                    end
                    if (i_m_tdata[15:8] != want.byte_index) begin
                        report_mismatch("byte_index", i_m_tdata[15:8], want.byte_index);
                    end
                    if (i_m_tlast !== want.frame_last) begin
                        report_mismatch("frame_last", i_m_tlast, want.frame_last);
                    end
                    if (i_m_tuser !== want.crc_ok) begin
                        report_mismatch("crc_ok", i_m_tuser, want.crc_ok);
                    end
                end
            end
        end
        o_pending = frame_expect.size();
    end

endmodule

### sim/tb_crc_checked_frame_receiver.sv
// Testbench top for the CRC-checked frame receiver: clock, reset, byte and frame length
// stimulus, output back-pressure, watchdog and verdict.
// Depends on crcfr_pkg, crcfr_tb_pkg and crcfr_checker (sim/crcfr_checker.sv).

`timescale 1ns / 1ps

module tb_crc_checked_frame_receiver;

    import crcfr_pkg::*;
    import crcfr_tb_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_TARGET = 925;
    localparam int HOLD_CYCLES = 250;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic [7:0]  s_tdata;
    logic        m_tready;
    logic        cfg_valid;
    logic [7:0]  cfg_data;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;
    wire         m_tlast;
    wire         m_tuser;
    wire         cfg_ready;

    int   fail_count;
    int   pending;
    logic s_fire;
    logic m_fire;
    logic cfg_fire;
    int   bytes_sent;
    bit   src_idle_on;
    bit   sink_idle_on;
    int   sink_hold_len;
    int   quiet_cycles = 0;

    crc_checked_frame_receiver uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    crcfr_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Handshakes seen at the rising edge, read back by the drivers at the falling edge
    always @(posedge i_clk) begin
        s_fire   <= s_tvalid && s_tready;
        m_fire   <= m_tvalid && m_tready;
        cfg_fire <= cfg_valid && cfg_ready;
    end

    // Watchdog: too many cycles with no item moving on any channel
    always @(negedge i_clk) begin
        if (!i_rst_n || s_fire || m_fire || cfg_fire) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Output side: random stalls, plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_len != 0) begin
                m_tready <= 1'b0;
                repeat (sink_hold_len) @(negedge i_clk);
                sink_hold_len = 0;
            end
            if (sink_idle_on) begin
                m_tready <= ($urandom_range(99) >= 18);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one byte, with an occasional gap first, and wait until it is taken
    task automatic send_byte(input logic [7:0] b);
        if (src_idle_on && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(negedge i_clk); while (!s_fire);
        bytes_sent++;
    endtask

    // Drain the block, then write the frame length register
    task automatic set_frame_len(input logic [7:0] len);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        // dropped bytes leave nothing to wait for, so allow the pipeline to empty
        repeat (4) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(negedge i_clk); while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    // Sync pair, random payload and big-endian CRC; corrupt flips one bit after the sync
    task automatic send_frame(input int len, input bit corrupt);
        logic [7:0]  fr [255];
        logic [15:0] crc;
        int          flip_at;
        fr[0] = SYNC_FIRST;
        fr[1] = SYNC_SECOND;
        for (int i = 2; i < len - 2; i++) begin
            fr[i] = 8'($urandom_range(255));
        end
        crc = CRC_INIT;
        for (int i = 0; i < len - 2; i++) begin
            crc = crc16_update(crc, fr[i]);
        end
        fr[len - 2] = crc[15:8];
        fr[len - 1] = crc[7:0];
        if (corrupt) begin
            flip_at     = $urandom_range(len - 1, 2);
            fr[flip_at] = fr[flip_at] ^ (8'h01 << $urandom_range(7));
        end
        for (int i = 0; i < len; i++) begin
            send_byte(fr[i]);
        end
    endtask

    // Stimulus and verdict
    initial begin
        int         phase_no;
        int         phase_start;
        int         pick;
        logic [7:0] frame_len;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        cfg_valid     = 1'b0;
        cfg_data      = 8'h00;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        sink_hold_len = 0;
        bytes_sent    = 0;
        i_rst_n       = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: shortest frames, hunt failures, good and bad CRC
        set_frame_len(8'd4);
        send_byte(8'h00);
        send_byte(SYNC_SECOND);
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_frame(4, 1'b0);
        send_frame(4, 1'b1);

        // Directed: length cut below the byte count mid-frame, next byte closes it
        set_frame_len(8'd10);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        set_frame_len(8'd4);
        send_byte(8'h7F);

        // Random phases: longest frame, reset length under a long output hold-off,
        // shortest length with no idling, then mostly short random lengths
        for (phase_no = 0; bytes_sent < ITEM_TARGET; phase_no++) begin
            case (phase_no)
                0: frame_len = 8'd255;
                1: frame_len = FRAME_LEN_RESET;
                2: frame_len = 8'd4;
                default: begin
                    if ($urandom_range(99) < 75) begin
                        frame_len = 8'($urandom_range(24, 5));
                    end else begin
                        frame_len = 8'($urandom_range(120, 25));
                    end
                end
            endcase
            set_frame_len(frame_len);
            src_idle_on  = (phase_no != 2);
            sink_idle_on = (phase_no != 2);
            phase_start  = bytes_sent;
            if (phase_no == 1) begin
                sink_hold_len = HOLD_CYCLES;
            end
            if (phase_no < 2) begin
                send_frame(frame_len, 1'b0);
            end
            while (phase_no != 0 && bytes_sent - phase_start < ((phase_no == 2) ? 150 : 90)) begin
                pick = $urandom_range(99);
                if (pick < 65) begin
                    send_frame(frame_len, $urandom_range(99) < 25);
                end else if (pick < 82) begin
                    // line noise, some of it looking like a first sync byte
                    repeat ($urandom_range(6, 1)) begin
                        send_byte(($urandom_range(99) < 20) ? SYNC_FIRST : 8'($urandom_range(255)));
                    end
                end else if (pick < 92) begin
                    // first sync byte followed by something else
                    send_byte(SYNC_FIRST);
                    send_byte(($urandom_range(99) < 30) ? SYNC_FIRST : 8'($urandom_range(255)));
                end else begin
                    // truncated frame; whatever follows is taken into it
                    send_byte(SYNC_FIRST);
                    send_byte(SYNC_SECOND);
                    repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### crc_checked_frame_receiver.f
hdl/crcfr_pkg.sv
hdl/crcfr_front.sv
hdl/crcfr_queue.sv
hdl/crcfr_back.sv
hdl/crc_checked_frame_receiver.sv
sim/crcfr_checker.sv
sim/tb_crc_checked_frame_receiver.sv
